// ===== rtl/bce_pkg.sv =====
// Shared types, constants and the binomial coefficient table for the
// Bezier curve evaluator. Depends on nothing; every other file uses it.
package bce_pkg;

   localparam int MAX_POINTS = 16;
   localparam int PIDX_W     = $clog2(MAX_POINTS);
   localparam int DEG_W      = 4;
   localparam int NPOW       = 1 << DEG_W;
   localparam int COORD_W    = 16;
   localparam int PARAM_W    = 17;
   localparam int FRAC_W     = 24;
   localparam int Q_W        = FRAC_W + 1;
   localparam int BINOM_W    = 13;
   localparam int WB_W       = Q_W + BINOM_W;
   localparam int MUL_A_W    = WB_W + 1;
   localparam int MUL_B_W    = Q_W + 1;
   localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
   localparam int ACC_W      = 48;

   localparam logic [Q_W-1:0]     ONE_Q  = Q_W'(1) << FRAC_W;
   localparam logic [ACC_W-1:0]   HALF_Q = ACC_W'(1) << (FRAC_W - 1);
   localparam logic [PARAM_W-1:0] T_MAX  = PARAM_W'(65536);
   localparam logic [DEG_W-1:0]   DEGREE_RESET = DEG_W'(3);

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_START,
      OP_UPOW,
      OP_WQ,
      OP_WB,
      OP_MX,
      OP_MY,
      OP_TNEXT,
      OP_FINISH
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UPOW,
      ST_WQ,
      ST_WB,
      ST_MX,
      ST_MY,
      ST_TNEXT,
      ST_DRAIN,
      ST_HOLD
   } ctl_state_type;

   typedef struct packed {
      op_type           op;
      logic [DEG_W-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic [DEG_W-1:0] n;
      logic             out_full;
   } status_type;

   // Pascal's triangle, row is the degree and column the point index.
   localparam logic [BINOM_W-1:0] BINOM [NPOW][NPOW] = '{
      '{1,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0},
      '{1,1,0,0,0,0,0,0,0,0,0,0,0,0,0,0},
      '{1,2,1,0,0,0,0,0,0,0,0,0,0,0,0,0},
      '{1,3,3,1,0,0,0,0,0,0,0,0,0,0,0,0},
      '{1,4,6,4,1,0,0,0,0,0,0,0,0,0,0,0},
      '{1,5,10,10,5,1,0,0,0,0,0,0,0,0,0,0},
      '{1,6,15,20,15,6,1,0,0,0,0,0,0,0,0,0},
      '{1,7,21,35,35,21,7,1,0,0,0,0,0,0,0,0},
      '{1,8,28,56,70,56,28,8,1,0,0,0,0,0,0,0},
      '{1,9,36,84,126,126,84,36,9,1,0,0,0,0,0,0},
      '{1,10,45,120,210,252,210,120,45,10,1,0,0,0,0,0},
      '{1,11,55,165,330,462,462,330,165,55,11,1,0,0,0,0},
      '{1,12,66,220,495,792,924,792,495,220,66,12,1,0,0,0},
      '{1,13,78,286,715,1287,1716,1716,1287,715,286,78,13,1,0,0},
      '{1,14,91,364,1001,2002,3003,3432,3003,2002,1001,364,91,14,1,0},
      '{1,15,105,455,1365,3003,5005,6435,6435,5005,3003,1365,455,105,15,1}
   };

endpackage

// ===== rtl/bce_ctrl.sv =====
// Sequencer for the Bezier curve evaluator: walks the power and weight
// steps, one command per cycle up to its drain state. Uses bce_pkg.
module bce_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_action,
   input  bce_pkg::status_type status,
   output bce_pkg::cmd_type    cmd
);

   bce_pkg::ctl_state_type       state_ff, state_in;
   logic [bce_pkg::DEG_W-1:0]    idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bce_pkg::ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      req_ready = 1'b0;
      cmd.op    = bce_pkg::OP_NONE;
      cmd.idx   = idx_ff;
      case (state_ff)
         bce_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (!req_action) begin
                  cmd.op = bce_pkg::OP_LOAD;
               end else begin
                  cmd.op = bce_pkg::OP_START;
                  if (status.n == '0) begin
                     idx_in   = '0;
                     state_in = bce_pkg::ST_WQ;
                  end else begin
                     idx_in   = bce_pkg::DEG_W'(1);
                     state_in = bce_pkg::ST_UPOW;
                  end
               end
            end
         end
         bce_pkg::ST_UPOW: begin
            cmd.op = bce_pkg::OP_UPOW;
            if (idx_ff == status.n) begin
               idx_in   = '0;
               state_in = bce_pkg::ST_WQ;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         bce_pkg::ST_WQ: begin
            cmd.op   = bce_pkg::OP_WQ;
            state_in = bce_pkg::ST_WB;
         end
         bce_pkg::ST_WB: begin
            cmd.op   = bce_pkg::OP_WB;
            state_in = bce_pkg::ST_MX;
         end
         bce_pkg::ST_MX: begin
            cmd.op   = bce_pkg::OP_MX;
            state_in = bce_pkg::ST_MY;
         end
         bce_pkg::ST_MY: begin
            cmd.op = bce_pkg::OP_MY;
            if (idx_ff == status.n) begin
               state_in = bce_pkg::ST_DRAIN;
            end else begin
               state_in = bce_pkg::ST_TNEXT;
            end
         end
         bce_pkg::ST_TNEXT: begin
            cmd.op   = bce_pkg::OP_TNEXT;
            idx_in   = idx_ff + 1'b1;
            state_in = bce_pkg::ST_WQ;
         end
         bce_pkg::ST_DRAIN: begin
            // The last y product is added to its sum in this cycle.
            state_in = bce_pkg::ST_HOLD;
         end
         bce_pkg::ST_HOLD: begin
            if (!status.out_full) begin
               cmd.op   = bce_pkg::OP_FINISH;
               state_in = bce_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bce_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/bce_datapath.sv =====
// Datapath of the Bezier curve evaluator: control point store, power table,
// one shared multiplier, sums and the result register. Uses bce_pkg.
module bce_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [bce_pkg::DEG_W-1:0]           csr_data,
   input  logic [bce_pkg::PIDX_W-1:0]          load_index,
   input  logic signed [bce_pkg::COORD_W-1:0]  load_x,
   input  logic signed [bce_pkg::COORD_W-1:0]  load_y,
   input  logic [bce_pkg::PARAM_W-1:0]         param_t,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic signed [bce_pkg::COORD_W-1:0]  curve_x,
   output logic signed [bce_pkg::COORD_W-1:0]  curve_y,
   input  bce_pkg::cmd_type                    cmd,
   output bce_pkg::status_type                 status
);

   logic [bce_pkg::DEG_W-1:0]                degree_ff;
   logic signed [bce_pkg::COORD_W-1:0]       px_ff [bce_pkg::MAX_POINTS];
   logic signed [bce_pkg::COORD_W-1:0]       py_ff [bce_pkg::MAX_POINTS];
   logic [bce_pkg::Q_W-1:0]                  upow_ff [bce_pkg::NPOW];
   logic [bce_pkg::Q_W-1:0]                  tq_ff, uq_ff, tcur_ff, ucur_ff, wq_ff;
   logic [bce_pkg::WB_W-1:0]                 wb_ff;
   logic signed [bce_pkg::ACC_W-1:0]         prod_ff, accx_ff, accy_ff;
   logic                                     addx_ff, addy_ff;
   logic                                     rsp_valid_ff;
   logic signed [bce_pkg::COORD_W-1:0]       curve_x_ff, curve_y_ff;

   logic [bce_pkg::DEG_W-1:0]                n;
   logic [bce_pkg::PARAM_W-1:0]              t_sat;
   logic [bce_pkg::Q_W-1:0]                  tq_in;
   logic [bce_pkg::PIDX_W-1:0]               pidx;
   logic [bce_pkg::DEG_W-1:0]                ridx;
   logic signed [bce_pkg::MUL_A_W-1:0]       mul_a;
   logic signed [bce_pkg::MUL_B_W-1:0]       mul_b;
   logic signed [bce_pkg::MUL_P_W-1:0]       mul_p;
   logic [bce_pkg::Q_W-1:0]                  mul_q;
   logic signed [bce_pkg::ACC_W-1:0]         rnd_x, rnd_y;

   always_comb begin
      if (int'(degree_ff) > bce_pkg::MAX_POINTS - 1) begin
         n = bce_pkg::DEG_W'(bce_pkg::MAX_POINTS - 1);
      end else begin
         n = degree_ff;
      end
   end

   assign t_sat = (param_t > bce_pkg::T_MAX) ? bce_pkg::T_MAX : param_t;
   assign tq_in = bce_pkg::Q_W'(t_sat) << (bce_pkg::FRAC_W - 16);
   assign pidx  = bce_pkg::PIDX_W'(cmd.idx);
   assign ridx  = n - cmd.idx;

   // One shared multiplier; the operands follow the command.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         bce_pkg::OP_UPOW: begin
            mul_a = bce_pkg::MUL_A_W'(ucur_ff);
            mul_b = bce_pkg::MUL_B_W'(uq_ff);
         end
         bce_pkg::OP_TNEXT: begin
            mul_a = bce_pkg::MUL_A_W'(tcur_ff);
            mul_b = bce_pkg::MUL_B_W'(tq_ff);
         end
         bce_pkg::OP_WQ: begin
            mul_a = bce_pkg::MUL_A_W'(tcur_ff);
            mul_b = bce_pkg::MUL_B_W'(upow_ff[ridx]);
         end
         bce_pkg::OP_WB: begin
            mul_a = bce_pkg::MUL_A_W'(wq_ff);
            mul_b = bce_pkg::MUL_B_W'(bce_pkg::BINOM[n][cmd.idx]);
         end
         bce_pkg::OP_MX: begin
            mul_a = bce_pkg::MUL_A_W'(wb_ff);
            mul_b = bce_pkg::MUL_B_W'(px_ff[pidx]);
         end
         bce_pkg::OP_MY: begin
            mul_a = bce_pkg::MUL_A_W'(wb_ff);
            mul_b = bce_pkg::MUL_B_W'(py_ff[pidx]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;
   assign mul_q = mul_p[bce_pkg::FRAC_W+bce_pkg::Q_W-1:bce_pkg::FRAC_W];

   // Floor of the sum plus one half; the low bits of the integer part are kept.
   assign rnd_x = accx_ff + bce_pkg::HALF_Q;
   assign rnd_y = accy_ff + bce_pkg::HALF_Q;

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff    <= bce_pkg::DEGREE_RESET;
         rsp_valid_ff <= 1'b0;
         addx_ff      <= 1'b0;
         addy_ff      <= 1'b0;
         for (int k = 0; k < bce_pkg::MAX_POINTS; k++) begin
            px_ff[k] <= '0;
            py_ff[k] <= '0;
         end
      end else begin
         if (csr_valid) begin
            degree_ff <= csr_data;
         end
         if (cmd.op == bce_pkg::OP_LOAD && int'(load_index) < bce_pkg::MAX_POINTS) begin
            px_ff[load_index] <= load_x;
            py_ff[load_index] <= load_y;
         end
         addx_ff <= (cmd.op == bce_pkg::OP_MX);
         addy_ff <= (cmd.op == bce_pkg::OP_MY);
         if (cmd.op == bce_pkg::OP_FINISH) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         bce_pkg::OP_START: begin
            tq_ff      <= tq_in;
            uq_ff      <= bce_pkg::ONE_Q - tq_in;
            tcur_ff    <= bce_pkg::ONE_Q;
            ucur_ff    <= bce_pkg::ONE_Q;
            upow_ff[0] <= bce_pkg::ONE_Q;
         end
         bce_pkg::OP_UPOW: begin
            ucur_ff          <= mul_q;
            upow_ff[cmd.idx] <= mul_q;
         end
         bce_pkg::OP_TNEXT: begin
            tcur_ff <= mul_q;
         end
         bce_pkg::OP_WQ: begin
            wq_ff <= mul_q;
         end
         bce_pkg::OP_WB: begin
            wb_ff <= mul_p[bce_pkg::WB_W-1:0];
         end
         bce_pkg::OP_MX, bce_pkg::OP_MY: begin
            prod_ff <= mul_p[bce_pkg::ACC_W-1:0];
         end
         bce_pkg::OP_FINISH: begin
            curve_x_ff <= rnd_x[bce_pkg::FRAC_W+bce_pkg::COORD_W-1:bce_pkg::FRAC_W];
            curve_y_ff <= rnd_y[bce_pkg::FRAC_W+bce_pkg::COORD_W-1:bce_pkg::FRAC_W];
         end
         default: begin
         end
      endcase
      if (cmd.op == bce_pkg::OP_START) begin
         accx_ff <= '0;
         accy_ff <= '0;
      end else begin
         if (addx_ff) begin
            accx_ff <= accx_ff + prod_ff;
         end
         if (addy_ff) begin
            accy_ff <= accy_ff + prod_ff;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign curve_x         = curve_x_ff;
   assign curve_y         = curve_y_ff;
   assign status.n        = n;
   assign status.out_full = rsp_valid_ff && !rsp_ready;

endmodule

// ===== rtl/bezier_curve_evaluator_core.sv =====
// Top level of the Bezier curve evaluator: joins the sequencer and the
// datapath. Uses bce_pkg, bce_ctrl and bce_datapath.
//
//   channel  ports   direction  carries
//   req      req_*   in         load of a control point, or evaluate at t
//   rsp      rsp_*   out        one curve point per evaluate
//   csr      csr_*   in         curve degree
//
// An evaluate uses the single shared multiplier to form each power, weight
// and weighted coordinate in turn. Reset clears the control points and sets
// the degree to 3. A finished result waits in its output register; loads go
// on meanwhile and the next evaluate stalls only at its end until that
// register is free.
module bezier_curve_evaluator_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_action,
   input  logic [3:0]                          req_point_index,
   input  logic signed [bce_pkg::COORD_W-1:0]  req_coord_x,
   input  logic signed [bce_pkg::COORD_W-1:0]  req_coord_y,
   input  logic [bce_pkg::PARAM_W-1:0]         req_param_t,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [bce_pkg::COORD_W-1:0]  rsp_curve_x,
   output logic signed [bce_pkg::COORD_W-1:0]  rsp_curve_y,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bce_pkg::DEG_W-1:0]           csr_data
);

   bce_pkg::cmd_type            cmd;
   bce_pkg::status_type         status;
   logic [bce_pkg::PIDX_W-1:0]  load_index;
   logic                        load_hit;
   logic                        load_valid;

   assign csr_ready = 1'b1;

   // Indexes beyond the store are dropped by turning the load into a no-op.
   assign load_hit   = int'(req_point_index) < bce_pkg::MAX_POINTS;
   assign load_index = bce_pkg::PIDX_W'(req_point_index);
   assign load_valid = req_valid && (req_action || load_hit);

   bce_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .status     (status),
      .cmd        (cmd)
   );

   bce_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .load_index (load_index),
      .load_x     (req_coord_x),
      .load_y     (req_coord_y),
      .param_t    (req_param_t),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .curve_x    (rsp_curve_x),
      .curve_y    (rsp_curve_y),
      .cmd        (load_valid || cmd.op != bce_pkg::OP_LOAD ? cmd
                   : bce_pkg::cmd_type'{op: bce_pkg::OP_NONE, idx: cmd.idx}),
      .status     (status)
   );

endmodule

// ===== tb/tb_bezier_curve_evaluator_core.sv =====
// Self-checking testbench for the Bezier curve evaluator core: control point loads,
// curve evaluations and degree writes, checked against an in-bench fixed point predictor.
// Depends on bce_pkg and bezier_curve_evaluator_core.
module tb_bezier_curve_evaluator_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_RANDOM = 1700;
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_EVAL = 1'b1;

   typedef struct {
      logic        action;
      logic [3:0]  idx;
      logic [15:0] x;
      logic [15:0] y;
      logic [16:0] t;
      logic        known;
      logic [15:0] ex;
      logic [15:0] ey;
   } stim_row_type;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
   } curve_pt_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_ready, req_action = 0;
   logic [3:0] req_point_index = 0;
   logic signed [15:0] req_coord_x = 0, req_coord_y = 0;
   logic [16:0] req_param_t = 0;
   logic rsp_valid, rsp_ready = 0;
   logic signed [15:0] rsp_curve_x, rsp_curve_y;
   logic csr_valid = 0, csr_ready;
   logic [3:0] csr_data = 0;

   bezier_curve_evaluator_core u_top (.*);

   always #5 clock = ~clock;

   // Predictor state.
   logic signed [15:0] ctl_xs [16];
   logic signed [15:0] ctl_ys [16];
   logic [3:0] cur_degree;

   curve_pt_type expected_points[$];
   curve_pt_type typed_points[$];
   logic typed_known[$];
   int errors = 0, mismatches = 0, n_evals = 0, n_loads = 0;
   int send_idle_pct = 0, recv_stall_pct = 0;

   function automatic logic [15:0] round_to_pixel(logic signed [63:0] s);
      logic signed [63:0] r;
      r = (s + 64'sd8388608) >>> 24;
      return r[15:0];
   endfunction

   function automatic curve_pt_type eval_curve(logic [16:0] t_in);
      logic [63:0] tq, uq, w, binom;
      logic [63:0] tp [16];
      logic [63:0] up [16];
      logic signed [63:0] sx, sy;
      int n;
      curve_pt_type p;
      tq = (t_in > 17'd65536 ? 64'd65536 : 64'(t_in)) << 8;
      uq = (64'd1 << 24) - tq;
      n = cur_degree;
      tp[0] = 64'd1 << 24;
      up[0] = 64'd1 << 24;
      for (int i = 1; i <= n; i++) begin
         tp[i] = (tp[i-1] * tq) >> 24;
         up[i] = (up[i-1] * uq) >> 24;
      end
      sx = 0;
      sy = 0;
      binom = 1;
      for (int i = 0; i <= n; i++) begin
         w = ((tp[i] * up[n-i]) >> 24) * binom;
         sx += 64'(ctl_xs[i]) * $signed(w);
         sy += 64'(ctl_ys[i]) * $signed(w);
         binom = binom * 64'(n - i) / 64'(i + 1);
      end
      p.x = round_to_pixel(sx);
      p.y = round_to_pixel(sy);
      return p;
   endfunction

   // Valid stays high from one item to the next unless the sender idles.
   task automatic send_item(stim_row_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_action <= r.action;
      req_point_index <= r.idx;
      req_coord_x <= r.x;
      req_coord_y <= r.y;
      req_param_t <= r.t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // The item has been taken by now: update the predictor.
      if (r.action == ACT_LOAD) begin
         ctl_xs[r.idx] = r.x;
         ctl_ys[r.idx] = r.y;
         n_loads++;
      end else begin
         expected_points.insert(expected_points.size(), eval_curve(r.t));
         typed_known.insert(typed_known.size(), r.known);
         typed_points.insert(typed_points.size(), '{r.ex, r.ey});
         n_evals++;
      end
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_degree(logic [3:0] d);
      wait_drained();
      csr_valid <= 1;
      csr_data <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cur_degree = d;
      csr_valid <= 0;
      @(posedge clock);
   endtask

   function automatic stim_row_type rand_item();
      stim_row_type r;
      r.action = ($urandom_range(99) < 45) ? ACT_EVAL : ACT_LOAD;
      r.idx = 4'($urandom_range(15));
      r.x = 16'($urandom());
      r.y = 16'($urandom());
      case ($urandom_range(5))
         0: r.t = 17'd65536;
         1: r.t = 17'($urandom_range(17'h1FFFF, 65537));
         2: r.t = 17'($urandom_range(3));
         default: r.t = 17'($urandom_range(65536));
      endcase
      r.known = 0;
      r.ex = 0;
      r.ey = 0;
      return r;
   endfunction

   // Response checker.
   always @(posedge clock) begin
      if (!reset) begin
         if ($urandom_range(99) < recv_stall_pct) rsp_ready <= 0;
         else rsp_ready <= 1;
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               errors++;
               if (mismatches++ < 10)
                  $display("unexpected item x=%0d y=%0d", rsp_curve_x, rsp_curve_y);
            end else begin
               curve_pt_type e, k;
               logic kn;
               e = expected_points.pop_front();
               k = typed_points.pop_front();
               kn = typed_known.pop_front();
               if (kn && e != k) errors++;
               if (rsp_curve_x !== e.x || rsp_curve_y !== e.y ||
                   (kn && (rsp_curve_x !== k.x || rsp_curve_y !== k.y))) begin
                  errors++;
                  if (mismatches++ < 10)
                     $display("mismatch: expected (%0d,%0d) got (%0d,%0d)",
                              $signed(e.x), $signed(e.y), rsp_curve_x, rsp_curve_y);
               end
            end
         end
      end
   end

   initial begin
      #50_000_000;
      $display("tb_bezier_curve_evaluator_core NOT OK");
      $finish;
   end

   initial begin
      stim_row_type dir [$];
      for (int i = 0; i < 16; i++) begin
         ctl_xs[i] = 0;
         ctl_ys[i] = 0;
      end
      cur_degree = bce_pkg::DEGREE_RESET;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed table. After reset all points are zero.
      dir.insert(dir.size(), '{ACT_EVAL, 0, 0, 0, 17'd32768, 1, 0, 0});
      dir.insert(dir.size(), '{ACT_LOAD, 0, 16'h8000, 16'h7FFF, 0, 0, 0, 0});
      dir.insert(dir.size(), '{ACT_LOAD, 1, 16'h1234, 16'hFFFF, 17'h1FFFF, 0, 0, 0});
      dir.insert(dir.size(), '{ACT_LOAD, 2, 16'h7FFF, 16'h8000, 0, 0, 0, 0});
      dir.insert(dir.size(), '{ACT_LOAD, 3, 16'h0005, 16'hFFF0, 0, 0, 0, 0});
      dir.insert(dir.size(), '{ACT_LOAD, 15, 16'h7FFF, 16'h7FFF, 0, 0, 0, 0});
      // t = 0 gives point 0, t = 1 and above gives point n.
      dir.insert(dir.size(),
                 '{ACT_EVAL, 9, 16'hFFFF, 16'hFFFF, 17'd0, 1, 16'h8000, 16'h7FFF});
      dir.insert(dir.size(), '{ACT_EVAL, 0, 0, 0, 17'd65536, 1, 16'h0005, 16'hFFF0});
      dir.insert(dir.size(), '{ACT_EVAL, 0, 0, 0, 17'h1FFFF, 1, 16'h0005, 16'hFFF0});
      dir.insert(dir.size(), '{ACT_EVAL, 0, 0, 0, 17'd65537, 1, 16'h0005, 16'hFFF0});
      dir.insert(dir.size(), '{ACT_EVAL, 0, 0, 0, 17'd1, 0, 0, 0});
      dir.insert(dir.size(), '{ACT_EVAL, 0, 0, 0, 17'd32768, 0, 0, 0});
      dir.insert(dir.size(), '{ACT_EVAL, 0, 0, 0, 17'd65535, 0, 0, 0});
      foreach (dir[i]) send_item(dir[i]);
      // Degree extremes.
      write_degree(4'd15);
      send_item('{ACT_EVAL, 0, 0, 0, 17'd65536, 1, 16'h7FFF, 16'h7FFF});
      send_item('{ACT_EVAL, 0, 0, 0, 17'd21845, 0, 0, 0});
      write_degree(4'd1);
      send_item('{ACT_EVAL, 0, 0, 0, 17'd32768, 0, 0, 0});
      write_degree(4'd0);
      send_item('{ACT_EVAL, 0, 0, 0, 17'd40000, 1, 16'h8000, 16'h7FFF});
      // Random phases with changing degree and idling.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 81; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 81; end
            3: begin send_idle_pct = 20; recv_stall_pct = 20; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         write_degree(ph == 0 ? 4'd15 : ph == 1 ? 4'd1 : 4'($urandom_range(15)));
         for (int i = 0; i < N_RANDOM / 8; i++) begin
            if (i == 100) wait_drained();
            send_item(rand_item());
         end
      end
      wait_drained();
      $display("Covered %0d loads and %0d evaluations over degrees 0 to 15,",
               n_loads, n_evals);
      $display("with sender gaps and receiver stalls in several mixes.");
      if (errors == 0 && expected_points.size() == 0)
         $display("tb_bezier_curve_evaluator_core OK");
      else
         $display("tb_bezier_curve_evaluator_core NOT OK");
      $finish;
   end
endmodule
